// ----- sv/pli_pkg.sv -----
// Shared constants and types for the piecewise linear interpolator.
// No dependencies; imported by every module of the block except pli_ram.
package pli_pkg;

  localparam int DATA_W     = 32;
  localparam int TBL_DEPTH  = 32;
  localparam int TBL_AW     = $clog2(TBL_DEPTH);
  localparam int NUSE_W     = 6;
  localparam int CFG_AW     = 3;
  localparam int STEP_W     = $clog2(DATA_W);
  localparam int IN_FIELDS_W = DATA_W + TBL_AW + 2 * DATA_W;
  localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_IN_LO   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_IN_HI   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_OUT_LO  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_OUT_HI  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ENTRIES = 3'd4;

  // Request kinds carried in tuser
  localparam logic MODE_EVAL = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Status from the multiply/divide unit back to the sequencer
  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [DATA_W-1:0] quot;
  } mdu_rsp_t;

endpackage

// ----- sv/pli_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/pli_mdu.sv -----
// Iterative unsigned multiply then divide: quot = (a * b) / d, flags quotient overflow.
// One shared 33-bit add/subtract unit does every step. Depends on pli_pkg.
module pli_mdu (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [pli_pkg::DATA_W-1:0] op_a,
  input  logic [pli_pkg::DATA_W-1:0] op_b,
  input  logic [pli_pkg::DATA_W-1:0] op_d,
  output pli_pkg::mdu_rsp_t      rsp
);
  import pli_pkg::*;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_CHK  = 2'd2;
  localparam logic [1:0] M_DIV  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0] hi_r, hi_nxt;
  logic [DATA_W-1:0] lo_r, lo_nxt;
  logic [DATA_W-1:0] mag_r, mag_nxt;
  logic [DATA_W-1:0] w_r, w_nxt;
  logic              ovf_r, ovf_nxt;
  logic              done_r, done_nxt;

  // shared adder
  logic [DATA_W:0]   alu_a, alu_b;
  logic              alu_sub;
  logic [DATA_W+1:0] alu_s;

  assign alu_s = {1'b0, alu_a} + ({1'b0, alu_b} ^ {(DATA_W+2){alu_sub}})
               + (DATA_W+2)'(alu_sub);

  always_comb begin
    alu_a   = {1'b0, hi_r};
    alu_b   = {1'b0, w_r};
    alu_sub = 1'b1;
    unique case (state_r)
      M_MUL: begin
        alu_b   = lo_r[0] ? {1'b0, mag_r} : '0;
        alu_sub = 1'b0;
      end
      M_DIV: alu_a = {hi_r, lo_r[DATA_W-1]};
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    mag_nxt   = mag_r;
    w_nxt     = w_r;
    ovf_nxt   = ovf_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      M_IDLE: begin
        if (start) begin
          hi_nxt    = '0;
          lo_nxt    = op_a;
          mag_nxt   = op_b;
          w_nxt     = op_d;
          ovf_nxt   = 1'b0;
          cnt_nxt   = STEP_W'(DATA_W - 1);
          state_nxt = M_MUL;
        end
      end
      M_MUL: begin
        hi_nxt  = alu_s[DATA_W:1];
        lo_nxt  = {alu_s[0], lo_r[DATA_W-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = M_CHK;
        end
      end
      M_CHK: begin
        // high half at or above divisor: quotient does not fit
        if (!alu_s[DATA_W+1]) begin
          ovf_nxt   = 1'b1;
          done_nxt  = 1'b1;
          state_nxt = M_IDLE;
        end else begin
          cnt_nxt   = STEP_W'(DATA_W - 1);
          state_nxt = M_DIV;
        end
      end
      M_DIV: begin
        if (!alu_s[DATA_W+1]) begin
          hi_nxt = alu_s[DATA_W-1:0];
        end else begin
          hi_nxt = alu_a[DATA_W-1:0];
        end
        lo_nxt  = {lo_r[DATA_W-2:0], ~alu_s[DATA_W+1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = M_IDLE;
        end
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    mag_r <= mag_nxt;
    w_r   <= w_nxt;
    ovf_r <= ovf_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.quot = lo_r;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == M_IDLE)
    else $error("mdu started while busy");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == M_DIV |-> hi_r < w_r)
    else $error("division remainder not below divisor");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == M_IDLE)
    else $error("done raised while unit still busy");
`endif

endmodule

// ----- sv/piecewise_linear_interpolator_unit.sv -----
// Piecewise linear interpolator with clamping, signed Q16.16.
// Depends on pli_pkg, pli_ram (breakpoint table) and pli_mdu (multiply/divide).
//
//   port group | dir | payload
//   in_*       | in  | tdata: sample, entry_index, entry_input, entry_output; tuser mode; tlast
//   out_*      | out | tdata: interpolated; tlast: last_result
//   cfg_*      | in  | write enable, register index, 32-bit data
//
// A load request writes the table when accepted; a clamped sample goes through S_DONE
// to the output register. An in-range sample runs a serial scan of n = clamped
// entries_in_use table entries (one RAM read per cycle), then 32 shift-add and 32
// restoring-divide steps on one adder. in_tready is low while a sample is in work; a
// result waits in the output register without blocking the next request. Reset (rst_n
// low, synchronous) resets control and config registers; the table keeps its contents.
module piecewise_linear_interpolator_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // sample[31:0], entry_index[36:32], entry_input[68:37], entry_output[100:69], zero pad
  input  logic [pli_pkg::IN_TDATA_W-1:0]   in_tdata,
  // mode: 0 evaluate, 1 load
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // interpolated[31:0]
  output logic [pli_pkg::DATA_W-1:0]       out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [pli_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [pli_pkg::DATA_W-1:0]       cfg_wdata
);
  import pli_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  localparam logic [NUSE_W-1:0] N_MIN = NUSE_W'(2);
  localparam logic [NUSE_W-1:0] N_MAX = NUSE_W'(TBL_DEPTH);

  // configuration registers
  logic [DATA_W-1:0] in_lo_r, in_hi_r, out_lo_r, out_hi_r;
  logic [NUSE_W-1:0] nuse_r;

  logic [2:0]        state_r, state_nxt;
  logic [DATA_W-1:0] x_r, x_nxt;
  logic              last_r, last_nxt;
  logic [NUSE_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              dv_r, dv_nxt;
  logic [TBL_AW-1:0] didx_r, didx_nxt;
  logic [DATA_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic              hit_r, hit_nxt, eq_r, eq_nxt;
  logic [DATA_W-1:0] eqy_r, eqy_nxt;
  logic [DATA_W-1:0] y0_r, y0_nxt, dx_r, dx_nxt, w_r, w_nxt, mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic              out_tlast_r, out_tlast_nxt;

  logic [NUSE_W-1:0]   n_eff;
  logic                in_acc;
  logic [DATA_W-1:0]   in_sample, in_ex, in_ey;
  logic [TBL_AW-1:0]   in_eidx;
  logic [2*DATA_W-1:0] rdata;
  logic [DATA_W-1:0]   xk, yk;
  logic [DATA_W:0]     dy_up, dy_dn;
  logic                scan_done, mdu_start;
  logic [DATA_W+1:0]   fin_s;
  mdu_rsp_t            mdu_rsp;

  assign in_sample = in_tdata[DATA_W-1:0];
  assign in_eidx   = in_tdata[DATA_W+TBL_AW-1:DATA_W];
  assign in_ex     = in_tdata[2*DATA_W+TBL_AW-1:DATA_W+TBL_AW];
  assign in_ey     = in_tdata[3*DATA_W+TBL_AW-1:2*DATA_W+TBL_AW];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign n_eff = (nuse_r < N_MIN) ? N_MIN : ((nuse_r > N_MAX) ? N_MAX : nuse_r);

  pli_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (in_acc && (in_tuser == MODE_LOAD)),
    .waddr (in_eidx),
    .wdata ({in_ey, in_ex}),
    .raddr (rd_idx_r[TBL_AW-1:0]),
    .rdata (rdata)
  );

  assign xk = rdata[DATA_W-1:0];
  assign yk = rdata[2*DATA_W-1:DATA_W];
  assign dy_up = {yk[DATA_W-1], yk} - {py_r[DATA_W-1], py_r};
  assign dy_dn = {py_r[DATA_W-1], py_r} - {yk[DATA_W-1], yk};

  assign scan_done = (state_r == S_SCAN) && (rd_idx_r == n_eff) && !dv_r;
  assign mdu_start = scan_done && hit_r;

  pli_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mdu_start),
    .op_a  (dx_r),
    .op_b  (mag_r),
    .op_d  (w_r),
    .rsp   (mdu_rsp)
  );

  assign fin_s = neg_r ? ({{2{y0_r[DATA_W-1]}}, y0_r} - {2'b00, mdu_rsp.quot})
                       : ({{2{y0_r[DATA_W-1]}}, y0_r} + {2'b00, mdu_rsp.quot});

  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    last_nxt       = last_r;
    rd_idx_nxt     = rd_idx_r;
    dv_nxt         = 1'b0;
    didx_nxt       = didx_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    hit_nxt        = hit_r;
    eq_nxt         = eq_r;
    eqy_nxt        = eqy_r;
    y0_nxt         = y0_r;
    dx_nxt         = dx_r;
    w_nxt          = w_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == MODE_EVAL)) begin
          x_nxt    = in_sample;
          last_nxt = in_tlast;
          if ($signed(in_sample) < $signed(in_lo_r)) begin
            res_nxt   = out_lo_r;
            state_nxt = S_DONE;
          end else if ($signed(in_sample) > $signed(in_hi_r)) begin
            res_nxt   = out_hi_r;
            state_nxt = S_DONE;
          end else begin
            rd_idx_nxt = '0;
            hit_nxt    = 1'b0;
            eq_nxt     = 1'b0;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_idx_r < n_eff) begin
          dv_nxt     = 1'b1;
          didx_nxt   = rd_idx_r[TBL_AW-1:0];
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (dv_r) begin
          px_nxt = xk;
          py_nxt = yk;
          if (didx_r == '0) begin
            if (x_r == xk) begin
              eq_nxt  = 1'b1;
              eqy_nxt = yk;
            end
          end else if (($signed(px_r) < $signed(x_r)) && ($signed(x_r) <= $signed(xk))) begin
            // later segments override earlier ones
            hit_nxt = 1'b1;
            y0_nxt  = py_r;
            dx_nxt  = x_r - px_r;
            w_nxt   = xk - px_r;
            neg_nxt = dy_up[DATA_W];
            mag_nxt = dy_up[DATA_W] ? dy_dn[DATA_W-1:0] : dy_up[DATA_W-1:0];
          end
        end
        if (scan_done) begin
          if (hit_r) begin
            state_nxt = S_CALC;
          end else begin
            res_nxt   = eq_r ? eqy_r : '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_CALC: begin
        if (mdu_rsp.done) begin
          if (mdu_rsp.ovf) begin
            res_nxt = neg_r ? SAT_MIN : SAT_MAX;
          end else if (fin_s[DATA_W+1:DATA_W-1] == 3'b000
                    || fin_s[DATA_W+1:DATA_W-1] == 3'b111) begin
            res_nxt = fin_s[DATA_W-1:0];
          end else begin
            res_nxt = fin_s[DATA_W+1] ? SAT_MIN : SAT_MAX;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = res_r;
          out_tlast_nxt  = last_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      dv_r         <= 1'b0;
      in_lo_r      <= '0;
      in_hi_r      <= DATA_W'(65536);
      out_lo_r     <= '0;
      out_hi_r     <= DATA_W'(65536);
      nuse_r       <= N_MIN;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      dv_r         <= dv_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_IN_LO:   in_lo_r  <= cfg_wdata;
          REG_IN_HI:   in_hi_r  <= cfg_wdata;
          REG_OUT_LO:  out_lo_r <= cfg_wdata;
          REG_OUT_HI:  out_hi_r <= cfg_wdata;
          REG_ENTRIES: nuse_r   <= cfg_wdata[NUSE_W-1:0];
          default: ;
        endcase
      end
    end
    x_r         <= x_nxt;
    last_r      <= last_nxt;
    rd_idx_r    <= rd_idx_nxt;
    didx_r      <= didx_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    hit_r       <= hit_nxt;
    eq_r        <= eq_nxt;
    eqy_r       <= eqy_nxt;
    y0_r        <= y0_nxt;
    dx_r        <= dx_nxt;
    w_r         <= w_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

`ifndef SYNTH
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == MODE_EVAL) |=> state_r != S_IDLE)
    else $error("evaluate request did not start work");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_rsp.done |-> state_r == S_CALC)
    else $error("mdu result arrived outside calc state");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && !out_tvalid_r |=> out_tvalid_r && state_r == S_IDLE)
    else $error("finished result not moved to output register");
`endif

endmodule

// ----- verif/pli_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for piecewise_linear_interpolator_unit: tracks config writes and table
// loads, predicts each evaluate request's result and compares it with the output stream.
// Depends on pli_pkg.
module pli_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [pli_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [pli_pkg::DATA_W-1:0]     out_tdata,
  input  logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [pli_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [pli_pkg::DATA_W-1:0]     cfg_wdata,
  output int                             mismatches,
  output int                             pending
);
  import pli_pkg::*;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } interp_result_t;

  interp_result_t results_due[$];

  logic signed [DATA_W-1:0] lim_lo, lim_hi, val_lo, val_hi;
  logic [NUSE_W-1:0]        scan_cfg;
  logic signed [DATA_W-1:0] knot_x [TBL_DEPTH];
  logic signed [DATA_W-1:0] knot_y [TBL_DEPTH];

  function automatic logic [DATA_W-1:0] segment_value(longint x, longint x0, longint x1,
                                                      longint y0, longint y1);
    longint unsigned run, span, rise, q;
    longint          dy, r;
    run  = x - x0;
    span = x1 - x0;
    dy   = y1 - y0;
    rise = (dy < 0) ? -dy : dy;
    q    = (run * rise) / span;
    r    = (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return r[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] predict_interpolated(logic signed [DATA_W-1:0] x);
    int                span_n;
    logic [DATA_W-1:0] res;
    if (x < lim_lo) return val_lo;
    if (x > lim_hi) return val_hi;
    span_n = (scan_cfg < 2) ? 2 : (scan_cfg > TBL_DEPTH) ? TBL_DEPTH : int'(scan_cfg);
    res = '0;
    if (x == knot_x[0]) res = knot_y[0];
    for (int i = 0; i + 1 < span_n; i++) begin
      if (knot_x[i] < x && x <= knot_x[i+1])
        res = segment_value(x, knot_x[i], knot_x[i+1], knot_y[i], knot_y[i+1]);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t ERROR %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    interp_result_t            want;
    logic [TBL_AW-1:0]         idx;
    logic signed [DATA_W-1:0]  smp;
    if (!rst_n) begin
      lim_lo   = 0;
      lim_hi   = 65536;
      val_lo   = 0;
      val_hi   = 65536;
      scan_cfg = NUSE_W'(2);
      pending  = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with no request waiting", out_tdata, '0);
        end else begin
          want = results_due.pop_front();
          if (out_tdata !== want.value) report_mismatch("interpolated", out_tdata, want.value);
          if (out_tlast !== want.last) begin
            report_mismatch("last_result", DATA_W'(out_tlast), DATA_W'(want.last));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        smp = in_tdata[DATA_W-1:0];
        idx = in_tdata[DATA_W +: TBL_AW];
        if (in_tuser == MODE_LOAD) begin
          knot_x[idx] = in_tdata[DATA_W + TBL_AW +: DATA_W];
          knot_y[idx] = in_tdata[2*DATA_W + TBL_AW +: DATA_W];
        end else begin
          want.value = predict_interpolated(smp);
          want.last  = in_tlast;
          results_due.push_back(want);
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_IN_LO:   lim_lo = cfg_wdata;
          REG_IN_HI:   lim_hi = cfg_wdata;
          REG_OUT_LO:  val_lo = cfg_wdata;
          REG_OUT_HI:  val_hi = cfg_wdata;
          REG_ENTRIES: scan_cfg = cfg_wdata[NUSE_W-1:0];
          default: ;
        endcase
      end
      pending = results_due.size();
    end
  end

endmodule

// ----- verif/tb_piecewise_linear_interpolator_unit.sv -----
`timescale 1ns / 1ps
// Top of the interpolator testbench: clock, reset, table loads, config phases and
// evaluate traffic with random gaps and output stalls. Depends on pli_pkg,
// pli_result_checker and piecewise_linear_interpolator_unit.
module tb_piecewise_linear_interpolator_unit;
  import pli_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int IDLE_GAP     = 128;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum int {FILL_NARROW, FILL_WIDE, FILL_SCRAMBLED} fill_kind_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;
  logic                  in_tuser   = MODE_EVAL;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_AW-1:0]     cfg_addr   = REG_IN_LO;
  logic [DATA_W-1:0]     cfg_wdata  = '0;
  int                    mismatches;
  int                    pending;

  logic signed [DATA_W-1:0] tbl_x [TBL_DEPTH];
  logic [DATA_W-1:0]        cur_lo, cur_hi;
  int                       cur_span;
  int                       burst_left = 0;
  int                       cycle_count = 0;
  int                       ready_mode = 0;
  int                       ready_left = 0;
  int                       items;

  piecewise_linear_interpolator_unit u_dut (.*);
  pli_result_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // output stall pattern: always ready, coin flip, long stalls, or rare stalls
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(16, 200);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  task automatic send_req(input logic mode, input logic [DATA_W-1:0] sample,
                          input logic [TBL_AW-1:0] idx, input logic [DATA_W-1:0] ex,
                          input logic [DATA_W-1:0] ey, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tlast  <= last;
    in_tdata  <= IN_TDATA_W'({ey, ex, idx, sample});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic load_entry(input int idx, input logic [DATA_W-1:0] ex,
                            input logic [DATA_W-1:0] ey);
    tbl_x[idx] = ex;
    send_req(MODE_LOAD, $urandom, TBL_AW'(idx), ex, ey, 1'($urandom_range(0, 1)));
  endtask

  task automatic eval_sample(input logic [DATA_W-1:0] x);
    send_req(MODE_EVAL, x, TBL_AW'($urandom_range(0, TBL_DEPTH - 1)), $urandom, $urandom,
             1'($urandom_range(0, 1)));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic set_config(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                            input logic [DATA_W-1:0] olo, input logic [DATA_W-1:0] ohi,
                            input logic [DATA_W-1:0] nraw);
    logic [NUSE_W-1:0] n6;
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_IN_LO;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_addr  <= REG_IN_HI;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_addr  <= REG_OUT_LO;
    cfg_wdata <= olo;
    @(posedge clk);
    cfg_addr  <= REG_OUT_HI;
    cfg_wdata <= ohi;
    @(posedge clk);
    cfg_addr  <= REG_ENTRIES;
    cfg_wdata <= nraw;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n6 = nraw[NUSE_W-1:0];
    cur_lo   = lo;
    cur_hi   = hi;
    cur_span = (n6 < 2) ? 2 : (n6 > TBL_DEPTH) ? TBL_DEPTH : int'(n6);
  endtask

  task automatic fill_table(input fill_kind_t kind, input longint origin);
    logic signed [DATA_W-1:0] xs [TBL_DEPTH];
    logic [DATA_W-1:0]        ys [TBL_DEPTH];
    longint                   x;
    int                       first;
    int                       slot;
    x = origin;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      case (kind)
        FILL_WIDE: begin
          // spans the whole input range, first and last at the extremes
          if (i == TBL_DEPTH - 1) xs[i] = 32'h7fffffff;
          else if (i == 0) xs[i] = 32'h80000000;
          else xs[i] = DATA_W'(-64'sd2147483648 + longint'(i) * 138547332
                               + longint'($urandom_range(0, 1048576)));
        end
        FILL_SCRAMBLED: xs[i] = $urandom;
        default: begin
          xs[i] = DATA_W'(x);
          x += ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom_range(1, 65536));
        end
      endcase
      ys[i] = ($urandom_range(0, 3) == 0)
            ? $urandom
            : DATA_W'(longint'($urandom_range(0, 2097152)) - 1048576);
    end
    first = $urandom_range(0, TBL_DEPTH - 1);
    for (int k = 0; k < TBL_DEPTH; k++) begin
      slot = (first + k) % TBL_DEPTH;
      load_entry(slot, xs[slot], ys[slot]);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_sample();
    int     i;
    longint w;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return tbl_x[$urandom_range(0, TBL_DEPTH - 1)];
      2: return tbl_x[0];
      3: begin
        case ($urandom_range(0, 3))
          0: return cur_lo;
          1: return cur_hi;
          2: return cur_lo - 1;
          default: return cur_hi + 1;
        endcase
      end
      4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: begin
        i = $urandom_range(0, cur_span - 2);
        w = longint'(tbl_x[i+1]) - longint'(tbl_x[i]);
        if (w <= 0) return $urandom;
        return DATA_W'(longint'(tbl_x[i]) + 1 + longint'({$urandom, $urandom} % w));
      end
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_output();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_config();
    logic [DATA_W-1:0] lo, hi, nraw;
    logic [NUSE_W-1:0] n6;
    int                span;
    case ($urandom_range(0, 5))
      0: nraw = 2;
      1: nraw = TBL_DEPTH;
      2: nraw = $urandom_range(0, 1);
      3: nraw = $urandom_range(33, 63);
      default: nraw = $urandom_range(2, 32);
    endcase
    if ($urandom_range(0, 3) == 0) nraw = nraw | ($urandom & ~32'h3f);
    n6 = nraw[NUSE_W-1:0];
    span = (n6 < 2) ? 2 : (n6 > TBL_DEPTH) ? TBL_DEPTH : int'(n6);
    case ($urandom_range(0, 4))
      0: begin
        lo = 32'h80000000;
        hi = 32'h7fffffff;
      end
      1: begin
        lo = $urandom;
        hi = $urandom;
      end
      2: begin
        lo = $urandom;
        hi = lo - $urandom_range(1, 1000);
      end
      default: begin
        lo = tbl_x[0] - $urandom_range(0, 4);
        hi = tbl_x[span-1] + $urandom_range(0, 4);
      end
    endcase
    set_config(lo, hi, pick_output(), pick_output(), nraw);
  endtask

  initial begin
    cur_lo   = 0;
    cur_hi   = 65536;
    cur_span = 2;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: first breakpoint, both clamps, limit edges, field extremes
    fill_table(FILL_NARROW, 0);
    eval_sample(0);
    eval_sample(32'hffffffff);
    eval_sample(65537);
    eval_sample(65536);
    eval_sample(32'h80000000);
    eval_sample(32'h7fffffff);
    eval_sample(tbl_x[1]);
    wait_idle();

    // no clamping; samples outside the table find no segment
    set_config(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 63);
    eval_sample(32'h80000000);
    eval_sample(32'h7fffffff);
    eval_sample(tbl_x[31]);
    eval_sample(tbl_x[0]);
    eval_sample(tbl_x[0] + 1);
    wait_idle();

    // crossed limits: low clamp wins, the rest clamp high
    set_config(100, -100, 32'h7fffffff, 32'h80000000, 0);
    eval_sample(0);
    eval_sample(200);
    eval_sample(-200);
    eval_sample(100);

    // descending last segment overlaps everything: highest index wins
    load_entry(30, 32'h80000000, 32'h7fffffff);
    load_entry(31, 32'h7fffffff, 32'h80000000);
    wait_idle();
    set_config(32'h80000000, 32'h7fffffff, 0, 0, TBL_DEPTH);
    eval_sample(tbl_x[5]);
    eval_sample(32'h7fffffff);
    eval_sample(32'h40000000);
    eval_sample(32'h80000001);
    wait_idle();

    items = 0;
    while (items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        fill_table(fill_kind_t'($urandom_range(0, 2)),
                   longint'($urandom_range(0, 2097152)) - 1048576);
        items += TBL_DEPTH;
        wait_idle();
      end
      random_config();
      repeat ($urandom_range(30, 60)) begin
        if ($urandom_range(0, 9) == 0)
          load_entry($urandom_range(0, TBL_DEPTH - 1), $urandom, $urandom);
        else
          eval_sample(pick_sample());
        items++;
      end
      wait_idle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
